// ----- src/kwm_pkg.sv -----
// Package for the k-way sorted merge block: stream field layout, defaults
// and configuration constants. No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

    // Default sizing handed to the top level
    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_VALUE_WIDTH = 32;

    // Configuration register: rows in use
    localparam int          CFG_W   = 4;
    localparam logic [3:0]  K_RESET = 4'd8;

    // Input stream layout: row, position, element value, zero pad
    localparam int ROW_FIELD_W = 3;
    localparam int POS_FIELD_W = 3;
    localparam int ELEM_W      = 32;
    localparam int ROW_LSB     = 0;
    localparam int POS_LSB     = ROW_LSB + ROW_FIELD_W;
    localparam int ELEM_LSB    = POS_LSB + POS_FIELD_W;
    localparam int IN_TDATA_W  = ((ELEM_LSB + ELEM_W + 7) / 8) * 8;

    // Output stream layout: merged value
    localparam int OUT_TDATA_W = 32;

endpackage

// ----- src/kwm_grid_mem.sv -----
// Grid store for the k-way sorted merge: one write port, one read port
// with registered read data. No package dependencies.
`timescale 1ns / 1ps

module kwm_grid_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/kwm_min_cmp.sv -----
// Shared compare unit of the k-way sorted merge: decides whether the
// candidate row head replaces the running minimum. No package dependencies.
`timescale 1ns / 1ps

module kwm_min_cmp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [VALUE_WIDTH-1:0] i_cand_val,
    input  logic                   i_cand_active,
    input  logic [VALUE_WIDTH-1:0] i_best_val,
    input  logic                   i_best_valid,
    output logic                   o_take
);

    // Strictly less keeps the lower row on ties, since rows are scanned upward
    assign o_take = i_cand_active &&
                    (!i_best_valid || ($signed(i_cand_val) < $signed(i_best_val)));

endmodule

// ----- src/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge: grid load, row-head registers and
// the sequencer around one shared compare unit. Uses kwm_pkg, kwm_grid_mem
// and kwm_min_cmp.
//
//  Channel   | Direction | Handshake                      | Payload (low bit up)
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | row, position, value; tlast = end
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | merged value; tlast = last result
//  cfg       | in        | i_cfg_we                       | k_in_use
//
// The end-of-load transaction seeds the row heads one row at a time, each with
// a grid read and a capture of the registered read data, and each merged value
// takes K compare steps on the shared compare unit, then a grid read to refill
// the popped row. The input is not ready during the merge. A full stall on
// m_axis holds the last compare step until the output register frees. Reset is
// synchronous, active low; the grid needs no clearing pass.
`timescale 1ns / 1ps

module k_way_sorted_merge import kwm_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row_index, position, element_value
    input  logic                   s_axis_tlast,   // end_of_load
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // merged_value
    output logic                   m_axis_tlast,   // last_result
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int K_W    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH  = MAX_ROWS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_LOAD     = 6'b000001,
        S_SEED     = 6'b000010,
        S_SEED_CAP = 6'b000100,
        S_SCAN     = 6'b001000,
        S_FETCH    = 6'b010000,
        S_REFILL   = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_k;
    logic [ROW_W-1:0]       r_idx, n_idx;
    logic [ROW_W-1:0]       r_best, n_best;
    logic                   r_best_valid, n_best_valid;
    logic [CNT_W-1:0]       r_left, n_left;
    logic [MAX_ROWS-1:0]    r_active, n_active;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_best_val;
    logic [VALUE_WIDTH-1:0] r_out_val;
    logic                   r_out_last;
    logic [VALUE_WIDTH-1:0] r_head_val [MAX_ROWS];
    logic [ROW_W-1:0]       r_head_pos [MAX_ROWS];

    logic [ROW_FIELD_W-1:0] w_row;
    logic [POS_FIELD_W-1:0] w_pos;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic                   w_in_range;
    logic                   w_in_acc;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic [ADDR_W-1:0]      w_fetch_addr;
    logic [VALUE_WIDTH-1:0] w_rd_data;
    logic [K_W-1:0]         w_k;
    logic                   w_idx_last;
    logic                   w_has_next;
    logic                   w_take;
    logic                   w_out_free;
    logic [ROW_W-1:0]       w_best_pos;

    // Unpack the input transaction
    assign w_row      = s_axis_tdata[ROW_LSB +: ROW_FIELD_W];
    assign w_pos      = s_axis_tdata[POS_LSB +: POS_FIELD_W];
    assign w_in_val   = VALUE_WIDTH'(signed'(s_axis_tdata[ELEM_LSB +: ELEM_W]));
    assign w_in_range = (int'(w_row) < MAX_ROWS) && (int'(w_pos) < MAX_ROWS);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_wr_addr  = ADDR_W'(ADDR_W'(w_row) * ADDR_W'(MAX_ROWS) + ADDR_W'(w_pos));

    // Rows in use, saturated to the grid size
    assign w_k = (r_k > CFG_W'(MAX_ROWS)) ? K_W'(MAX_ROWS) : K_W'(r_k);

    assign w_idx_last = (K_W'(r_idx) + K_W'(1)) == w_k;
    assign w_best_pos = r_head_pos[r_best];
    assign w_has_next = (K_W'(w_best_pos) + K_W'(1)) < w_k;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_fetch_addr = w_has_next ?
        ADDR_W'(ADDR_W'(r_best) * ADDR_W'(MAX_ROWS) + ADDR_W'(w_best_pos) + ADDR_W'(1)) :
        '0;

    // Select the grid read address
    always_comb begin
        unique case (r_state)
            S_SEED:  w_rd_addr = ADDR_W'(ADDR_W'(r_idx) * ADDR_W'(MAX_ROWS));
            S_FETCH: w_rd_addr = w_fetch_addr;
            default: w_rd_addr = '0;
        endcase
    end

    kwm_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && w_in_range),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_in_val),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    kwm_min_cmp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .i_cand_val    (r_head_val[r_idx]),
        .i_cand_active (r_active[r_idx]),
        .i_best_val    (r_best_val),
        .i_best_valid  (r_best_valid),
        .o_take        (w_take)
    );

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_valid = r_best_valid;
        n_left       = r_left;
        n_active     = r_active;
        n_out_valid  = r_out_valid && !m_axis_tready;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast && (w_k != '0)) begin
                    n_state  = S_SEED;
                    n_idx    = '0;
                    n_left   = CNT_W'(CNT_W'(w_k) * CNT_W'(w_k));
                    n_active = '0;
                end
            end
            S_SEED: begin
                n_state = S_SEED_CAP;
            end
            S_SEED_CAP: begin
                n_active[r_idx] = 1'b1;
                if (w_idx_last) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_best_valid = 1'b0;
                end else begin
                    n_state = S_SEED;
                    n_idx   = r_idx + ROW_W'(1);
                end
            end
            S_SCAN: begin
                if (w_take) begin
                    n_best       = r_idx;
                    n_best_valid = 1'b1;
                end
                if (w_idx_last) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_left      = r_left - CNT_W'(1);
                        n_state     = S_FETCH;
                    end
                end else begin
                    n_idx = r_idx + ROW_W'(1);
                end
            end
            S_FETCH: begin
                n_state = S_REFILL;
            end
            S_REFILL: begin
                if (!w_has_next) begin
                    n_active[r_best] = 1'b0;
                end
                if (r_left == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_best_valid = 1'b0;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_k          <= K_RESET;
            r_idx        <= '0;
            r_best       <= '0;
            r_best_valid <= 1'b0;
            r_left       <= '0;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_best       <= n_best;
            r_best_valid <= n_best_valid;
            r_left       <= n_left;
            r_active     <= n_active;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
        end
    end

    // Row heads, running minimum and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEED_CAP) begin
            r_head_val[r_idx] <= w_rd_data;
            r_head_pos[r_idx] <= '0;
        end
        if ((r_state == S_REFILL) && w_has_next) begin
            r_head_val[r_best] <= w_rd_data;
            r_head_pos[r_best] <= w_best_pos + ROW_W'(1);
        end
        if ((r_state == S_SCAN) && w_take) begin
            r_best_val <= r_head_val[r_idx];
        end
        if ((r_state == S_SCAN) && w_idx_last && w_out_free) begin
            r_out_val  <= w_take ? r_head_val[r_idx] : r_best_val;
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_val);
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- src/kwm_checker.sv -----
// Port-level checks for the k-way sorted merge and the bind that attaches
// them to the top level. Uses kwm_pkg.
`timescale 1ns / 1ps

module kwm_checker import kwm_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   i_cfg_we,
    input logic [CFG_W-1:0]       i_cfg_wdata
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A pending result that is not the last means the merge is still running
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a merge");

    // After a non-final result transaction the merge goes on
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("merge ended before its last result");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_wdata   (i_cfg_wdata)
);

// ----- bench/kwm_merge_checker.sv -----
// Scoreboard for the k-way sorted merge: watches the load, result and
// configuration ports, predicts the merged run and compares it field by field.
// Depends on kwm_pkg for the stream layout.
`timescale 1ns / 1ps

module kwm_merge_checker import kwm_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row_index, position, element_value
    input  logic                   s_axis_tlast,   // end_of_load
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // merged_value
    input  logic                   m_axis_tlast,   // last_result
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              last;
    } t_merged;

    logic signed [ELEM_W-1:0] grid_copy [MAX_ROWS][MAX_ROWS];
    logic [CFG_W-1:0]         rows_in_use;
    t_merged                  merged_q [$];

    // Queue the whole merged run: repeatedly take the smallest row head,
    // lower row first on equal values, then advance that row.
    task automatic queue_merge_order();
        int      span;
        int      head [MAX_ROWS];
        int      pick;
        int      n;
        int      r;
        t_merged item;
        span = (rows_in_use > MAX_ROWS) ? MAX_ROWS : int'(rows_in_use);
        for (r = 0; r < MAX_ROWS; r++) head[r] = 0;
        for (n = 0; n < span * span; n++) begin
            pick = -1;
            for (r = 0; r < span; r++) begin
                if (head[r] < span) begin
                    if (pick < 0) begin
                        pick = r;
                    end else if (grid_copy[r][head[r]] < grid_copy[pick][head[pick]]) begin
                        pick = r;
                    end
                end
            end
            item.value = grid_copy[pick][head[pick]];
            item.last  = (n == span * span - 1);
            merged_q = {merged_q, item};
            head[pick]++;
        end
    endtask

    // Sample at the falling edge: values seen here are the ones the next
    // rising edge acts on, since everything changes only on rising edges.
    always @(negedge i_clk) begin : watch
        t_merged                got;
        t_merged                want;
        logic [ROW_FIELD_W-1:0] row_sel;
        logic [POS_FIELD_W-1:0] pos_sel;
        if (!i_rst_n) begin
            rows_in_use = K_RESET;
            merged_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) rows_in_use = i_cfg_wdata;

            // Compare each result transaction against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata;
                got.last  = m_axis_tlast;
                if (merged_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got value %0d last %0b",
                             $time, $signed(got.value), got.last);
                end else begin
                    want = merged_q.pop_front();
                    if (got.value !== want.value) begin
                        o_fail_count++;
                        $display("%0t: merged_value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.value), $signed(got.value));
                    end
                    if (got.last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: last_result mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end

            // Store each load transaction; the end of the load starts a run
            if (s_axis_tvalid && s_axis_tready) begin
                row_sel = s_axis_tdata[ROW_LSB +: ROW_FIELD_W];
                pos_sel = s_axis_tdata[POS_LSB +: POS_FIELD_W];
                grid_copy[row_sel][pos_sel] = s_axis_tdata[ELEM_LSB +: ELEM_W];
                if (s_axis_tlast) queue_merge_order();
            end
        end
        o_pending = merged_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the k-way sorted merge: clock, reset, load stimulus,
// result back-pressure and the verdict. Depends on kwm_pkg, k_way_sorted_merge
// and kwm_merge_checker.
`timescale 1ns / 1ps

module tb_top;
    import kwm_pkg::*;

    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int ITEM_TARGET  = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT      = 20;
    localparam int QUIET_LIMIT  = 4000;

    localparam logic signed [ELEM_W-1:0] VAL_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] VAL_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

    typedef enum logic [1:0] {FILL_FULL, FILL_TIED, FILL_EXTREME} t_fill_style;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // row_index, position, element_value
    logic                   s_axis_tlast = 1'b0;  // end_of_load
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // merged_value
    logic                   m_axis_tlast;         // last_result
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit gaps_on = 1'b1;

    logic [CFG_W-1:0]         rows_cfg = K_RESET;
    logic signed [ELEM_W-1:0] load_plan [MAX_ROWS][MAX_ROWS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    k_way_sorted_merge dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    kwm_merge_checker #(.MAX_ROWS(MAX_ROWS)) merge_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Offer one grid element, after a random gap if gaps are on; return at the accepting edge
    task automatic offer_element(input int row, input int pos,
                                 input logic [ELEM_W-1:0] value, input bit last);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[ROW_LSB +: ROW_FIELD_W] = ROW_FIELD_W'(row);
        word[POS_LSB +: POS_FIELD_W] = POS_FIELD_W'(pos);
        word[ELEM_LSB +: ELEM_W]     = value;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Let every expected result drain and the block go idle, then set the row count
    task automatic settle_then_configure(input logic [CFG_W-1:0] k_next);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k_next;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_cfg = k_next;
    endtask

    // Fill the square of rows in use with values of one style, sorted per row if asked
    task automatic fill_plan(input int span, input t_fill_style style, input bit sorted);
        int                       r;
        int                       p;
        int                       q;
        logic signed [ELEM_W-1:0] swap;
        for (r = 0; r < span; r++) begin
            for (p = 0; p < span; p++) begin
                case (style)
                    FILL_TIED: begin
                        load_plan[r][p] = int'($urandom_range(0, 4)) - 2;
                    end
                    FILL_EXTREME: begin
                        case ($urandom_range(0, 4))
                            0:       load_plan[r][p] = VAL_MIN;
                            1:       load_plan[r][p] = -1;
                            2:       load_plan[r][p] = 0;
                            3:       load_plan[r][p] = 1;
                            default: load_plan[r][p] = VAL_MAX;
                        endcase
                    end
                    default: begin
                        load_plan[r][p] = $urandom;
                    end
                endcase
            end
            if (sorted) begin
                for (p = 0; p < span - 1; p++) begin
                    for (q = 0; q < span - 1 - p; q++) begin
                        if (load_plan[r][q] > load_plan[r][q+1]) begin
                            swap              = load_plan[r][q];
                            load_plan[r][q]   = load_plan[r][q+1];
                            load_plan[r][q+1] = swap;
                        end
                    end
                end
            end
        end
    endtask

    // Send count shuffled slots of the square, the last ending the load (span 0: one stray end)
    task automatic load_plan_cells(input int span, input int count);
        int order [MAX_ROWS*MAX_ROWS];
        int i;
        int j;
        int t;
        int slot;
        if (span == 0) begin
            offer_element($urandom_range(0, 7), $urandom_range(0, 7), $urandom, 1'b1);
        end else begin
            for (i = 0; i < span * span; i++) order[i] = i;
            for (i = span * span - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            for (i = 0; i < count; i++) begin
                slot = order[i];
                offer_element(slot / span, slot % span, load_plan[slot / span][slot % span],
                              i == count - 1);
            end
        end
    endtask

    // One random run: maybe a new row count, some stray stores, then a full or partial reload
    task automatic run_random_merge();
        int          pick;
        int          span;
        int          count;
        t_fill_style style;
        pick = $urandom_range(0, 19);
        if (pick == 6) begin
            settle_then_configure('0);
        end else if (pick > 6 && pick < 10) begin
            settle_then_configure(CFG_W'($urandom_range(MAX_ROWS, 15)));
        end else if (pick >= 10) begin
            settle_then_configure(CFG_W'($urandom_range(1, MAX_ROWS - 1)));
        end
        span    = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        gaps_on = ($urandom_range(0, 3) != 0);
        style   = t_fill_style'($urandom_range(0, 2));
        fill_plan(span, style, $urandom_range(0, 4) != 0);
        repeat ($urandom_range(0, 2)) begin
            offer_element($urandom_range(0, 7), $urandom_range(0, 7), $urandom, 1'b0);
        end
        count = span * span;
        if (span > 0 && $urandom_range(0, 4) == 0) count = $urandom_range(1, span * span);
        load_plan_cells(span, count);
    endtask

    // Result side: random stalls, stall-free stretches, and one long hold-off
    initial begin : result_sink
        int wait_cycles;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) steady = ($urandom_range(0, 3) == 0);
            wait_cycles = steady ? 0 : $urandom_range(0, 12);
            if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge i_clk); while (!m_axis_tvalid);
            @(posedge i_clk);
            taken++;
        end
    end

    // Abort if no transaction moves for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("k_way_sorted_merge verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full grid under the reset row count; every entry is written from here on
        fill_plan(MAX_ROWS, FILL_FULL, 1'b1);
        load_plan_cells(MAX_ROWS, MAX_ROWS * MAX_ROWS);
        // Offer stray stores during the merge and its long result hold-off; they are taken after it
        repeat (4) offer_element($urandom_range(0, 7), $urandom_range(0, 7), $urandom, 1'b0);

        // Single row of one element at the most negative value
        gaps_on = 1'b0;
        settle_then_configure(4'd1);
        load_plan[0][0] = VAL_MIN;
        load_plan_cells(1, 1);

        // Extremes and equal values across rows: lower row pops first
        settle_then_configure(4'd2);
        load_plan[0][0] = -1;
        load_plan[0][1] = VAL_MAX;
        load_plan[1][0] = VAL_MIN;
        load_plan[1][1] = -1;
        load_plan_cells(2, 4);

        // Unsorted rows go through the same procedure
        settle_then_configure(4'd3);
        load_plan[0][0] = 5;
        load_plan[0][1] = -3;
        load_plan[0][2] = 7;
        load_plan[1][0] = 0;
        load_plan[1][1] = 9;
        load_plan[1][2] = -9;
        load_plan[2][0] = VAL_MAX;
        load_plan[2][1] = VAL_MIN;
        load_plan[2][2] = 0;
        load_plan_cells(3, 9);

        // Zero rows: end of load with no result
        settle_then_configure(4'd0);
        offer_element(7, 7, VAL_MAX, 1'b1);

        // Row count above the grid saturates; merge the stored grid again
        settle_then_configure(4'd15);
        offer_element(0, 0, 0, 1'b1);

        // Random runs
        gaps_on = 1'b1;
        while (items_sent < ITEM_TARGET) run_random_merge();

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("k_way_sorted_merge verification clean");
        end else begin
            $display("k_way_sorted_merge verification failed");
        end
        $finish;
    end

endmodule
